### rtl/ple_pkg.sv
// Shared types and codes for the positional list engine.
package ple_pkg;

	localparam int VALUE_W = 32;
	localparam int POS_W   = 16;
	localparam int OIDX_W  = 6;
	localparam int LEN_W   = 7;

	typedef logic [2:0] action_t;
	typedef logic [2:0] status_t;

	localparam action_t ACT_PREPEND = 3'd0;
	localparam action_t ACT_APPEND  = 3'd1;
	localparam action_t ACT_INSERT  = 3'd2;
	localparam action_t ACT_ERASE   = 3'd3;
	localparam action_t ACT_DUMP    = 3'd4;

	localparam status_t ST_OK    = 3'd0;
	localparam status_t ST_NEG   = 3'd1;
	localparam status_t ST_CLAMP = 3'd2;
	localparam status_t ST_FULL  = 3'd3;
	localparam status_t ST_EMPTY = 3'd4;

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_SHRD  = 10'b00_0000_0010,
		S_SHWR  = 10'b00_0000_0100,
		S_ERRD  = 10'b00_0000_1000,
		S_ERCAP = 10'b00_0001_0000,
		S_ERSH  = 10'b00_0010_0000,
		S_ERWR  = 10'b00_0100_0000,
		S_DMRD  = 10'b00_1000_0000,
		S_DMOUT = 10'b01_0000_0000,
		S_RES   = 10'b10_0000_0000
	} state_t;

endpackage

### rtl/ple_store.sv
// Entry storage: one write port and one registered read port.
module ple_store #(
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [ple_pkg::VALUE_W-1:0] wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [ple_pkg::VALUE_W-1:0] rdata
);
	import ple_pkg::*;

	logic [VALUE_W-1:0] mem_q [DEPTH];
	logic [VALUE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/positional_list_engine.sv
// Top level: bounded ordered list with push, insert, erase and dump actions.
// Errors, full pushes and empty dumps load the result directly. An insert moves each entry
// from index p up one slot, then writes the value; an erase reads entry p, then moves each
// later entry down. Dump reads, then outputs each entry. A new item is taken the cycle after
// the last result loads; unused action codes give no result. A stalled output holds the sequencer.
// Reset clears the entry count and control state; entry contents stay undefined.
module positional_list_engine #(
	parameter int CAPACITY = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  ple_pkg::action_t                  action,
	input  logic signed [ple_pkg::VALUE_W-1:0] item_value,
	input  logic signed [ple_pkg::POS_W-1:0]   position,
	output logic                              out_valid,
	input  logic                              out_stall,
	output ple_pkg::status_t                  status,
	output logic signed [ple_pkg::VALUE_W-1:0] out_value,
	output logic [ple_pkg::OIDX_W-1:0]         out_index,
	output logic [ple_pkg::LEN_W-1:0]          list_length,
	output logic                              last
);
	import ple_pkg::*;

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   cur_q;
	logic [CNT_W-1:0]   pos_q;
	status_t            pst_q;
	logic [VALUE_W-1:0] pval_q;
	logic [OIDX_W-1:0]  pidx_q;
	logic [LEN_W-1:0]   plen_q;

	logic               out_valid_q;
	status_t            status_q;
	logic [VALUE_W-1:0] value_q;
	logic [OIDX_W-1:0]  index_q;
	logic [LEN_W-1:0]   length_q;
	logic               last_q;

	logic               mem_we;
	logic               mem_re;
	logic [IDX_W-1:0]   mem_waddr;
	logic [IDX_W-1:0]   mem_raddr;
	logic [VALUE_W-1:0] mem_wdata;
	logic [VALUE_W-1:0] rd_data;

	logic [POS_W-1:0]   pos_u;
	logic               pos_neg;
	logic               pos_ge;
	logic               full;
	logic [CNT_W-1:0]   cur_m1;
	logic [CNT_W:0]     cur_p1;
	logic               out_free;
	logic               res_load;
	logic [CNT_W-1:0]   ins_tgt;
	status_t            ins_st;
	logic [CNT_W-1:0]   er_tgt;
	status_t            er_st;

	ple_store #(.DEPTH(CAPACITY)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rd_data)
	);

	assign pos_u    = POS_W'($unsigned(position));
	assign pos_neg  = position[POS_W-1];
	assign pos_ge   = pos_u >= POS_W'(cnt_q);
	assign full     = cnt_q >= CNT_W'(CAPACITY);
	assign cur_m1   = cur_q - CNT_W'(1);
	assign cur_p1   = {1'b0, cur_q} + (CNT_W+1)'(1);
	assign out_free = !out_valid_q || !out_stall;
	assign res_load = ((state_q == S_DMOUT) || (state_q == S_RES)) && out_free;
	assign in_stall = (state_q != S_IDLE);

	// Pick the slot a new value lands in.
	always_comb begin
		ins_tgt = CNT_W'(pos_u);
		ins_st  = ST_OK;
		if (action == ACT_PREPEND || (action == ACT_INSERT && pos_u == '0)) begin
			ins_tgt = '0;
		end else if (action == ACT_APPEND) begin
			ins_tgt = cnt_q;
		end else if (pos_ge) begin
			ins_tgt = cnt_q;
			ins_st  = ST_CLAMP;
		end
	end

	always_comb begin
		er_tgt = CNT_W'(pos_u);
		er_st  = ST_OK;
		if (pos_ge) begin
			er_tgt = cnt_q - CNT_W'(1);
			er_st  = ST_CLAMP;
		end
	end

	// Storage port control per sequencer step.
	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = cur_q[IDX_W-1:0];
		mem_raddr = cur_q[IDX_W-1:0];
		mem_wdata = rd_data;
		case (state_q)
			S_SHRD: begin
				if (cur_q == pos_q) begin
					mem_we    = 1'b1;
					mem_wdata = pval_q;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = cur_m1[IDX_W-1:0];
				end
			end
			S_SHWR: begin
				mem_we = 1'b1;
			end
			S_ERRD: begin
				mem_re    = 1'b1;
				mem_raddr = pos_q[IDX_W-1:0];
			end
			S_ERSH: begin
				if (cur_p1 < {1'b0, cnt_q}) begin
					mem_re    = 1'b1;
					mem_raddr = cur_p1[IDX_W-1:0];
				end
			end
			S_ERWR: begin
				mem_we = 1'b1;
			end
			S_DMRD: begin
				mem_re = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (action)
							ACT_PREPEND, ACT_APPEND, ACT_INSERT: begin
								pval_q <= item_value;
								pidx_q <= '0;
								plen_q <= LEN_W'(cnt_q);
								if (action == ACT_INSERT && pos_neg) begin
									pst_q   <= ST_NEG;
									state_q <= S_RES;
								end else if (full) begin
									pst_q   <= ST_FULL;
									state_q <= S_RES;
								end else begin
									pst_q   <= ins_st;
									pos_q   <= ins_tgt;
									cur_q   <= cnt_q;
									pidx_q  <= OIDX_W'(ins_tgt);
									plen_q  <= LEN_W'(cnt_q) + LEN_W'(1);
									state_q <= S_SHRD;
								end
							end
							ACT_ERASE: begin
								pval_q <= '0;
								pidx_q <= '0;
								plen_q <= LEN_W'(cnt_q);
								if (pos_neg) begin
									pst_q   <= ST_NEG;
									state_q <= S_RES;
								end else if (cnt_q == '0) begin
									pst_q   <= ST_EMPTY;
									state_q <= S_RES;
								end else begin
									pst_q   <= er_st;
									pos_q   <= er_tgt;
									pidx_q  <= OIDX_W'(er_tgt);
									plen_q  <= LEN_W'(cnt_q) - LEN_W'(1);
									state_q <= S_ERRD;
								end
							end
							ACT_DUMP: begin
								if (cnt_q == '0) begin
									pst_q   <= ST_EMPTY;
									pval_q  <= '0;
									pidx_q  <= '0;
									plen_q  <= '0;
									state_q <= S_RES;
								end else begin
									cur_q   <= '0;
									state_q <= S_DMRD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SHRD: begin
					if (cur_q == pos_q) begin
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= S_RES;
					end else begin
						state_q <= S_SHWR;
					end
				end
				S_SHWR: begin
					cur_q   <= cur_m1;
					state_q <= S_SHRD;
				end
				S_ERRD: begin
					state_q <= S_ERCAP;
				end
				S_ERCAP: begin
					pval_q  <= rd_data;
					cur_q   <= pos_q;
					state_q <= S_ERSH;
				end
				S_ERSH: begin
					if (cur_p1 < {1'b0, cnt_q}) begin
						state_q <= S_ERWR;
					end else begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= S_RES;
					end
				end
				S_ERWR: begin
					cur_q   <= cur_p1[CNT_W-1:0];
					state_q <= S_ERSH;
				end
				S_DMRD: begin
					state_q <= S_DMOUT;
				end
				S_DMOUT: begin
					// hold the read data until the output register frees up
					if (out_free) begin
						status_q    <= ST_OK;
						value_q     <= rd_data;
						index_q     <= OIDX_W'(cur_q);
						length_q    <= LEN_W'(cnt_q);
						last_q      <= (cur_p1 == {1'b0, cnt_q});
						if (cur_p1 == {1'b0, cnt_q}) begin
							state_q <= S_IDLE;
						end else begin
							cur_q   <= cur_p1[CNT_W-1:0];
							state_q <= S_DMRD;
						end
					end
				end
				S_RES: begin
					if (out_free) begin
						status_q    <= pst_q;
						value_q     <= pval_q;
						index_q     <= pidx_q;
						length_q    <= plen_q;
						last_q      <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign out_value   = value_q;
	assign out_index   = index_q;
	assign list_length = length_q;
	assign last        = last_q;

endmodule

### sim/tb.sv
// Testbench for the positional list engine: directed and random list actions checked against a queue model.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ple_pkg::*;

	localparam int LIST_CAP    = 16;
	localparam int QUIET_LIMIT = 2000;
	localparam int DRAIN_WAIT  = 40;

	localparam action_t ACT_UNUSED_FIRST = 3'd5;
	localparam action_t ACT_UNUSED_LAST  = 3'd7;

	typedef struct {
		status_t            status;
		logic signed [31:0] value;
		logic [5:0]         index;
		logic [6:0]         length;
		logic               last;
	} list_result_t;

	logic                              clk         = 1'b0;
	logic                              arst_n      = 1'b0;
	logic                              in_valid    = 1'b0;
	logic                              in_stall;
	action_t                           action      = ACT_PREPEND;
	logic signed [VALUE_W-1:0]         item_value  = '0;
	logic signed [POS_W-1:0]           position    = '0;
	logic                              out_valid;
	logic                              out_stall   = 1'b0;
	status_t                           status;
	logic signed [VALUE_W-1:0]         out_value;
	logic [OIDX_W-1:0]                 out_index;
	logic [LEN_W-1:0]                  list_length;
	logic                              last;

	logic signed [31:0] list_cells[$];
	list_result_t       pending_results[$];
	list_result_t       oldest;

	int  fail_count   = 0;
	int  quiet_cycles = 0;
	int  stall_left   = 0;
	int  hold_left    = 0;
	bit  send_gaps    = 1'b1;
	bit  sink_gaps    = 1'b1;

	positional_list_engine #(.CAPACITY(LIST_CAP)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.item_value(item_value),
		.position(position),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.out_value(out_value),
		.out_index(out_index),
		.list_length(list_length),
		.last(last)
	);

	always #5 clk = ~clk;

	task automatic report_mismatch(string what);
		if (fail_count < 40)
			$display("%0t ns: %s", $time, what);
		fail_count++;
	endtask

	function automatic void queue_result(status_t st, logic signed [31:0] v, int idx, int len,
			bit lst);
		list_result_t r;
		r.status = st;
		r.value  = v;
		r.index  = idx[5:0];
		r.length = len[6:0];
		r.last   = lst;
		pending_results.insert(pending_results.size(), r);
	endfunction

	// Apply one accepted item to the list copy and queue the results it causes.
	function automatic void apply_action(action_t act, logic signed [31:0] v,
			logic signed [15:0] p);
		int n;
		int at;
		logic signed [31:0] gone;
		n = list_cells.size();
		case (act)
			ACT_PREPEND, ACT_APPEND, ACT_INSERT: begin
				if (act == ACT_INSERT && p < 0) begin
					queue_result(ST_NEG, v, 0, n, 1'b1);
				end else if (n >= LIST_CAP) begin
					queue_result(ST_FULL, v, 0, n, 1'b1);
				end else if (act == ACT_PREPEND || (act == ACT_INSERT && p == 0)) begin
					list_cells.insert(0, v);
					queue_result(ST_OK, v, 0, n + 1, 1'b1);
				end else if (act == ACT_APPEND) begin
					list_cells.insert(n, v);
					queue_result(ST_OK, v, n, n + 1, 1'b1);
				end else if (p >= n) begin
					list_cells.insert(n, v);
					queue_result(ST_CLAMP, v, n, n + 1, 1'b1);
				end else begin
					list_cells.insert(int'(p), v);
					queue_result(ST_OK, v, p, n + 1, 1'b1);
				end
			end
			ACT_ERASE: begin
				if (p < 0) begin
					queue_result(ST_NEG, '0, 0, n, 1'b1);
				end else if (n == 0) begin
					queue_result(ST_EMPTY, '0, 0, 0, 1'b1);
				end else begin
					at = (p >= n) ? n - 1 : int'(p);
					gone = list_cells[at];
					list_cells.delete(at);
					queue_result((p >= n) ? ST_CLAMP : ST_OK, gone, at, n - 1, 1'b1);
				end
			end
			ACT_DUMP: begin
				if (n == 0)
					queue_result(ST_EMPTY, '0, 0, 0, 1'b1);
				else
					for (int i = 0; i < n; i++)
						queue_result(ST_OK, list_cells[i], i, n, i == n - 1);
			end
			default: ;
		endcase
	endfunction

	task automatic send_item(action_t act, logic signed [31:0] v, logic signed [15:0] p);
		int gap;
		if (send_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= act;
		item_value <= v;
		position   <= p;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		apply_action(act, v, p);
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return 32'sh0;
			3: return -32'sd1;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic signed [15:0] pick_position(int n);
		int r;
		r = $urandom_range(0, 19);
		if (r < 14)
			return 16'($urandom_range(0, n + 1));
		case (r)
			14: return 16'sh7FFF;
			15: return 16'sh8000;
			16: return -16'sd1;
			default: return 16'($urandom());
		endcase
	endfunction

	task automatic random_item(int grow_pct);
		int r;
		action_t act;
		r = $urandom_range(0, 99);
		if (r < 3)
			act = action_t'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
		else if (r < 12)
			act = ACT_DUMP;
		else if ($urandom_range(0, 99) < grow_pct)
			act = action_t'($urandom_range(ACT_PREPEND, ACT_INSERT));
		else
			act = ACT_ERASE;
		send_item(act, pick_value(), pick_position(list_cells.size()));
	endtask

	task automatic test_empty_list();
		send_item(ACT_DUMP, 32'sd0, 16'sd0);
		send_item(ACT_ERASE, 32'sd0, 16'sd0);
		send_item(ACT_ERASE, 32'sd0, -16'sd1);
		send_item(ACT_INSERT, 32'sh7FFF_FFFF, 16'sh8000);
	endtask

	task automatic test_positions();
		send_item(ACT_PREPEND, 32'sh7FFF_FFFF, 16'sd0);
		send_item(ACT_APPEND, 32'sh8000_0000, 16'sd0);
		send_item(ACT_INSERT, 32'sd1, 16'sd0);
		send_item(ACT_INSERT, -32'sd1, 16'sd1);
		send_item(ACT_INSERT, 32'sh5A5A_5A5A, 16'sh7FFF);
		send_item(ACT_INSERT, 32'shA5A5_A5A5, 16'sd5);
		send_item(ACT_DUMP, 32'sd0, 16'sd0);
		send_item(ACT_ERASE, 32'sd0, 16'sd0);
		send_item(ACT_ERASE, 32'sd0, 16'sd2);
		send_item(ACT_ERASE, 32'sd0, 16'sh7FFF);
		send_item(ACT_ERASE, 32'sd0, 16'sd3);
		send_item(ACT_DUMP, 32'sd0, 16'sd0);
	endtask

	task automatic test_unused_actions();
		for (int a = ACT_UNUSED_FIRST; a <= ACT_UNUSED_LAST; a++)
			send_item(action_t'(a), 32'shFFFF_FFFF, -16'sd1);
	endtask

	task automatic test_full_list();
		while (list_cells.size() < LIST_CAP)
			send_item(action_t'($urandom_range(ACT_PREPEND, ACT_INSERT)), pick_value(),
				pick_position(list_cells.size()));
		send_item(ACT_PREPEND, pick_value(), 16'sd0);
		send_item(ACT_APPEND, pick_value(), 16'sd0);
		send_item(ACT_INSERT, pick_value(), 16'sd3);
		send_item(ACT_INSERT, pick_value(), -16'sd1);
		send_item(ACT_DUMP, 32'sd0, 16'sd0);
		send_item(ACT_ERASE, 32'sd0, 16'sh8000);
		send_item(ACT_ERASE, 32'sd0, 16'sh7FFF);
		send_item(ACT_INSERT, pick_value(), 16'sd7);
		send_item(ACT_DUMP, 32'sd0, 16'sd0);
	endtask

	task automatic test_random(int count, int grow_pct);
		for (int k = 0; k < count; k++) begin
			// for each stretch of 30 items, pick at random whether sender and receiver idle
			if (k % 30 == 0) begin
				send_gaps = $urandom_range(0, 3) != 0;
				sink_gaps = $urandom_range(0, 3) != 0;
			end
			random_item(grow_pct);
		end
		send_gaps = 1'b1;
		sink_gaps = 1'b1;
	endtask

	task automatic test_backpressure();
		send_gaps = 1'b0;
		hold_left = 300;
		for (int k = 0; k < 14; k++)
			random_item(60);
		send_gaps = 1'b1;
	endtask

	task automatic test_no_idle();
		send_gaps = 1'b0;
		sink_gaps = 1'b0;
		for (int k = 0; k < 60; k++)
			random_item(55);
	endtask

	// Receiver: random stall bursts, plus a long hold when one is requested.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 15);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending, value %0d", out_value));
			end else begin
				oldest = pending_results.pop_front();
				if (status !== oldest.status)
					report_mismatch($sformatf("status got %0d want %0d", status, oldest.status));
				if (out_value !== oldest.value)
					report_mismatch($sformatf("out_value got %0d want %0d", out_value,
						oldest.value));
				if (out_index !== oldest.index)
					report_mismatch($sformatf("out_index got %0d want %0d", out_index,
						oldest.index));
				if (list_length !== oldest.length)
					report_mismatch($sformatf("list_length got %0d want %0d", list_length,
						oldest.length));
				if (last !== oldest.last)
					report_mismatch($sformatf("last got %0b want %0b", last, oldest.last));
			end
		end
	end

	// Watchdog: end the run when no item moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_list();
		test_positions();
		test_unused_actions();
		test_random(70, 75);
		test_full_list();
		test_backpressure();
		test_random(70, 30);
		test_random(70, 60);
		test_random(70, 85);
		test_random(70, 40);
		test_no_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
